>>> hw/rtl/sdfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdfr_pkg;

  // Widths fixed by the register map and the result fields.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned LEN_W       = 3;
  localparam int unsigned PATTERN_W   = 32;
  localparam int unsigned INDEX_OUT_W = 6;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SENTINEL_LENGTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SENTINEL_PATTERN = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_CAPACITY   = 8'd2;

  // Register reset values.
  localparam logic [LEN_W-1:0]     SENTINEL_LENGTH_RST  = 3'd4;
  localparam logic [PATTERN_W-1:0] SENTINEL_PATTERN_RST = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0]   FRAME_CAPACITY_RST   = 7'd64;

  // Raw configuration as written by software.
  typedef struct packed {
    logic [LEN_W-1:0]     sentinel_length;
    logic [PATTERN_W-1:0] sentinel_pattern;
    logic [COUNT_W-1:0]   frame_capacity;
  } cfg_t;

  // One result of the frame core.
  typedef struct packed {
    logic                   stored;
    logic [INDEX_OUT_W-1:0] store_index;
    logic [BYTE_W-1:0]      stored_byte;
    logic                   frame_end;
    logic [INDEX_OUT_W-1:0] payload_length;
    logic                   overflow;
  } result_t;

  // Sentinel byte counted from the end; bytes beyond the pattern read as zero.
  function automatic logic [BYTE_W-1:0] sentinel_byte(logic [PATTERN_W-1:0] pattern,
                                                      int unsigned back);
    logic [PATTERN_W-1:0] shifted;
    shifted = pattern >> (BYTE_W * back);
    return shifted[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sdfr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sdfr_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [sdfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sdfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sdfr_pkg::cfg_t                      cfg
);
  import sdfr_pkg::*;

  cfg_t regs;

  // Register writes; an index beyond the map is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sentinel_length  <= SENTINEL_LENGTH_RST;
      regs.sentinel_pattern <= SENTINEL_PATTERN_RST;
      regs.frame_capacity   <= FRAME_CAPACITY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SENTINEL_LENGTH:  regs.sentinel_length  <= cfg_data[LEN_W-1:0];
        REG_SENTINEL_PATTERN: regs.sentinel_pattern <= cfg_data[PATTERN_W-1:0];
        REG_FRAME_CAPACITY:   regs.frame_capacity   <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

>>> hw/rtl/sdfr_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sdfr_frame_core #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned MAX_SENTINEL = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sdfr_pkg::cfg_t            cfg,
  input  wire logic                      step,
  input  wire logic [sdfr_pkg::BYTE_W-1:0] rx_byte,
  output sdfr_pkg::result_t              result
);
  import sdfr_pkg::*;

  localparam int unsigned AW    = $clog2(BUFFER_DEPTH);
  localparam int unsigned CMP_W = $clog2(BUFFER_DEPTH + (1 << COUNT_W));
  localparam int unsigned SL_W  = $clog2(MAX_SENTINEL + (1 << LEN_W));

  logic [COUNT_W-1:0] frame_count;
  logic [COUNT_W-1:0] frame_count_next;
  logic [BYTE_W-1:0]  recent_bytes [MAX_SENTINEL];
  logic [BYTE_W-1:0]  recent_next  [MAX_SENTINEL];
  logic [BYTE_W-1:0]  frame_store  [BUFFER_DEPTH];

  logic [COUNT_W-1:0] cap_eff;
  logic [LEN_W-1:0]   len_eff;
  logic               full;
  logic [COUNT_W-1:0] count_inc;
  logic               match;
  logic [AW-1:0]      store_addr;

  // Effective capacity and sentinel length after saturation; a zero length counts as one.
  always_comb begin
    if (CMP_W'(cfg.frame_capacity) > CMP_W'(BUFFER_DEPTH)) begin
      cap_eff = COUNT_W'(BUFFER_DEPTH);
    end else begin
      cap_eff = cfg.frame_capacity;
    end
    if (cfg.sentinel_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (SL_W'(cfg.sentinel_length) > SL_W'(MAX_SENTINEL)) begin
      len_eff = LEN_W'(MAX_SENTINEL);
    end else begin
      len_eff = cfg.sentinel_length;
    end
  end

  // Byte history after this byte, newest first.
  always_comb begin
    recent_next[0] = rx_byte;
    for (int i = 1; i < MAX_SENTINEL; i++) begin
      recent_next[i] = recent_bytes[i-1];
    end
  end

  // Parallel sentinel match over the newest bytes of the frame.
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_SENTINEL; i++) begin
      if ((LEN_W + 1)'(i) < (LEN_W + 1)'(len_eff) &&
          recent_next[i] != sentinel_byte(cfg.sentinel_pattern, i)) begin
        match = 1'b0;
      end
    end
  end

  // Result and next count for the byte at hand.
  always_comb begin
    full       = frame_count >= cap_eff;
    count_inc  = frame_count + COUNT_W'(1);
    store_addr = AW'(frame_count);
    result     = '0;
    if (full) begin
      result.overflow  = 1'b1;
      frame_count_next = '0;
    end else begin
      result.stored      = 1'b1;
      result.store_index = frame_count[INDEX_OUT_W-1:0];
      result.stored_byte = rx_byte;
      frame_count_next   = count_inc;
      if (count_inc >= COUNT_W'(len_eff) && match) begin
        result.frame_end      = 1'b1;
        result.payload_length = INDEX_OUT_W'(count_inc - COUNT_W'(len_eff));
        frame_count_next      = '0;
      end
    end
  end

  // Frame state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      for (int i = 0; i < MAX_SENTINEL; i++) begin
        recent_bytes[i] <= '0;
      end
    end else if (step) begin
      frame_count <= frame_count_next;
      if (!full) begin
        for (int i = 0; i < MAX_SENTINEL; i++) begin
          recent_bytes[i] <= recent_next[i];
        end
      end
    end
  end

  // Frame buffer write port.
  always_ff @(posedge clk) begin
    if (step && !full) begin
      frame_store[store_addr] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sentinel_delimited_frame_receiver_unit.sv
// Sentinel-delimited frame receiver.
// Input channel (in_valid/in_ready, rx_byte) takes one received byte per
// transaction. Each byte yields exactly one result transaction on the output
// channel (out_valid/out_ready): whether and where the byte was stored, a
// frame end flag with the payload length, and an overflow flag.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// sentinel length, sentinel pattern and frame capacity; it is always ready and
// should be used only while no byte is in flight.
// An accepted byte passes one input register stage, then the sentinel compare
// and count update into the result register. Throughput is one byte per cycle
// while the output side accepts results, set by the combinational compare and
// the single write port of the frame buffer.
// When the output side stalls, both stages hold and in_ready drops once the
// input stage is occupied; no transaction is lost or repeated.
// Reset clears both stages, the frame count and the byte history, and loads
// the register defaults (length 4, pattern all ones, capacity 64). The frame
// buffer contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sentinel_delimited_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned MAX_SENTINEL = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sdfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sdfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [sdfr_pkg::BYTE_W-1:0]      rx_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  stored,
  output logic [sdfr_pkg::INDEX_OUT_W-1:0]      store_index,
  output logic [sdfr_pkg::BYTE_W-1:0]           stored_byte,
  output logic                                  frame_end,
  output logic [sdfr_pkg::INDEX_OUT_W-1:0]      payload_length,
  output logic                                  overflow
);
  import sdfr_pkg::*;

  cfg_t              cfg;
  result_t           core_result;
  result_t           out_result;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              out_open;
  logic              s1_advance;

  // Configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  sdfr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Pipeline flow control.
  assign out_open   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_open;
  assign in_ready   = !s1_valid || s1_advance;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  sdfr_frame_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .MAX_SENTINEL (MAX_SENTINEL)
  ) u_frame_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (s1_advance),
    .rx_byte (s1_byte),
    .result  (core_result)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result <= core_result;
    end
  end

  assign stored         = out_result.stored;
  assign store_index    = out_result.store_index;
  assign stored_byte    = out_result.stored_byte;
  assign frame_end      = out_result.frame_end;
  assign payload_length = out_result.payload_length;
  assign overflow       = out_result.overflow;

endmodule

`default_nettype wire

>>> tb/sentinel_delimited_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps

module sentinel_delimited_frame_receiver_unit_tb;
  import sdfr_pkg::*;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned SENT_MAX  = 4;
  localparam int unsigned PER_PHASE = 105;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [BYTE_W-1:0]      rx_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   stored;
  logic [INDEX_OUT_W-1:0] store_index;
  logic [BYTE_W-1:0]      stored_byte;
  logic                   frame_end;
  logic [INDEX_OUT_W-1:0] payload_length;
  logic                   overflow;

  // Bytes waiting to be sent, and results predicted for accepted bytes.
  logic [BYTE_W-1:0] rx_backlog[$];
  result_t           predicted_results[$];

  // Shadow of the register file and of the frame state.
  logic [LEN_W-1:0]           cfg_sentinel_len = SENTINEL_LENGTH_RST;
  logic [PATTERN_W-1:0]       cfg_pattern      = SENTINEL_PATTERN_RST;
  logic [COUNT_W-1:0]         cfg_capacity     = FRAME_CAPACITY_RST;
  logic [COUNT_W-1:0]         frame_bytes      = '0;
  logic [3:0][BYTE_W-1:0]     byte_history     = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          sender_hold = 1'b0;
  int unsigned mismatch_count = 0;

  sentinel_delimited_frame_receiver_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stored         (stored),
    .store_index    (store_index),
    .stored_byte    (stored_byte),
    .frame_end      (frame_end),
    .payload_length (payload_length),
    .overflow       (overflow)
  );

  // Clock, reset level and known input values from time zero.
  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    out_ready = 1'b0;
    forever #5 clk = ~clk;
  end

  // Effective sentinel length: zero counts as one, large values saturate.
  function automatic int unsigned sentinel_span();
    if (cfg_sentinel_len == 0) begin
      return 1;
    end
    return (cfg_sentinel_len > SENT_MAX) ? SENT_MAX : cfg_sentinel_len;
  endfunction

  function automatic int unsigned usable_capacity();
    return (cfg_capacity > DEPTH) ? DEPTH : cfg_capacity;
  endfunction

  // Advance the shadow frame state by one byte and return its result.
  function automatic result_t receive_byte(input logic [BYTE_W-1:0] b);
    result_t     r;
    int unsigned slen;
    int unsigned k;
    int unsigned diff;
    bit          hit;
    r = '0;
    slen = sentinel_span();
    if (frame_bytes >= usable_capacity()) begin
      // Full buffer: the byte is dropped and the frame restarts.
      frame_bytes = '0;
      r.overflow = 1'b1;
      return r;
    end
    r.stored      = 1'b1;
    r.store_index = frame_bytes[INDEX_OUT_W-1:0];
    r.stored_byte = b;
    byte_history  = {byte_history[2:0], b};
    frame_bytes   = frame_bytes + 7'd1;
    if (frame_bytes >= slen) begin
      hit = 1'b1;
      for (k = 0; k < slen; k++) begin
        if (byte_history[k] != cfg_pattern[8*k +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        diff             = frame_bytes - slen;
        r.frame_end      = 1'b1;
        r.payload_length = diff[INDEX_OUT_W-1:0];
        frame_bytes      = '0;
      end
    end
    return r;
  endfunction

  // Queue a frame body followed by the first tail_len bytes of the sentinel.
  function automatic int unsigned queue_frame(input int unsigned body_len,
                                              input int unsigned tail_len);
    int unsigned slen;
    int unsigned k;
    logic [BYTE_W-1:0] b;
    slen = sentinel_span();
    for (k = 0; k < body_len; k++) begin
      // Sentinel bytes inside the body provoke partial and early matches.
      if ($urandom_range(3) == 0) begin
        b = cfg_pattern[8*$urandom_range(slen - 1) +: 8];
      end else begin
        b = BYTE_W'($urandom);
      end
      rx_backlog.push_back(b);
    end
    for (k = 0; k < tail_len; k++) begin
      rx_backlog.push_back(cfg_pattern[8*(slen - 1 - k) +: 8]);
    end
    return body_len + tail_len;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // The write transaction completes at this edge.
    if (idx == REG_SENTINEL_LENGTH) begin
      cfg_sentinel_len = data[LEN_W-1:0];
    end else if (idx == REG_SENTINEL_PATTERN) begin
      cfg_pattern = data;
    end else if (idx == REG_FRAME_CAPACITY) begin
      cfg_capacity = data[COUNT_W-1:0];
    end
    cfg_valid <= 1'b0;
    cfg_index <= CFG_INDEX_W'($urandom);
    cfg_data  <= $urandom;
  endtask

  // Junk in the unused upper bits checks that the block masks them.
  task automatic configure(input int unsigned len, input logic [31:0] pattern,
                           input int unsigned cap);
    write_reg(REG_SENTINEL_LENGTH, ($urandom & ~32'h7) | len);
    write_reg(REG_SENTINEL_PATTERN, pattern);
    write_reg(REG_FRAME_CAPACITY, ($urandom & ~32'h7F) | cap);
  endtask

  task automatic wait_drained();
    while (rx_backlog.size() != 0 || in_valid || predicted_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Input driver: predicts each accepted byte, then offers the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        predicted_results.push_back(receive_byte(rx_byte));
      end
      if (!sender_hold && rx_backlog.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte  <= rx_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
        rx_byte  <= BYTE_W'($urandom);
      end
    end
  end

  // Result monitor: each result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got stored=%0d overflow=%0d",
                   $time, stored, overflow);
        end else begin
          check_field("stored", predicted_results[0].stored, stored);
          check_field("store_index", predicted_results[0].store_index, store_index);
          check_field("stored_byte", predicted_results[0].stored_byte, stored_byte);
          check_field("frame_end", predicted_results[0].frame_end, frame_end);
          check_field("payload_length", predicted_results[0].payload_length,
                      payload_length);
          check_field("overflow", predicted_results[0].overflow, overflow);
          void'(predicted_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5ms;
    $display("sentinel_delimited_frame_receiver_unit_tb: errors");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned sent;
    int unsigned slen;
    int unsigned room;
    int unsigned pick;
    int unsigned k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a four-byte all-ones sentinel. The first frame holds
    // one data byte; the frame after it is shorter than the sentinel.
    rx_backlog.push_back(8'h00);
    repeat (4) rx_backlog.push_back(8'hFF);
    repeat (2) rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(8'h7F);
    wait_drained();

    // Writes past the register list must leave every setting unchanged.
    write_reg(8'd3, 32'h0000_0001);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    rx_backlog.push_back(8'hFF);
    wait_drained();

    // Zero sentinel length acts as a single byte.
    configure(0, 32'h1234_5678, 64);
    rx_backlog.push_back(8'h78);
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'h78);
    wait_drained();

    // Oversized length and capacity saturate.
    configure(7, 32'h1234_5678, 127);
    rx_backlog.push_back(8'h12);
    rx_backlog.push_back(8'h34);
    rx_backlog.push_back(8'h56);
    rx_backlog.push_back(8'h78);
    wait_drained();

    // Zero capacity drops every byte.
    configure(2, 32'h0000_0000, 0);
    rx_backlog.push_back(8'hA5);
    rx_backlog.push_back(8'h5A);
    wait_drained();

    // Capacity lowered below a partly received frame.
    configure(2, 32'h0000_0000, 64);
    for (k = 1; k <= 6; k++) rx_backlog.push_back(BYTE_W'(k));
    wait_drained();
    configure(2, 32'h0000_0000, 5);
    rx_backlog.push_back(8'h01);
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(8'h00);
    wait_drained();

    // Random frames: four idling modes, two register settings in each.
    for (phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: configure(4, 32'hFFFF_FFFF, 64);
        1: configure(1, 32'h0000_0000, 1);
        2: configure(2, $urandom, 127);
        3: configure(0, $urandom, 8);
        default: configure($urandom_range(0, 7), $urandom, $urandom_range(0, 70));
      endcase
      case (phase / 2)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      slen = sentinel_span();
      room = (usable_capacity() > slen) ? usable_capacity() - slen : 0;
      sent = 0;
      while (sent < PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // Well-formed frame, mostly with a short body.
          if ($urandom_range(3) == 0) begin
            sent += queue_frame($urandom_range(0, room), slen);
          end else begin
            sent += queue_frame($urandom_range(0, (room < 6) ? room : 6), slen);
          end
        end else if (pick < 87) begin
          sent += queue_frame($urandom_range(0, 4),
                              (slen > 1) ? $urandom_range(1, slen - 1) : 0);
        end else if (pick < 96) begin
          sent += queue_frame($urandom_range(1, 8), 0);
        end else begin
          // A run long enough to overflow any capacity.
          sent += queue_frame(DEPTH + 4, 0);
        end
      end
      if (phase == 5) begin
        // Stop sending mid-phase until every result is back.
        while (rx_backlog.size() > sent / 2) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || predicted_results.size() != 0) @(posedge clk);
        sender_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sentinel_delimited_frame_receiver_unit_tb: clean");
    end else begin
      $display("sentinel_delimited_frame_receiver_unit_tb: errors");
    end
    $finish;
  end

endmodule
